// ===== hw/rtl/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and codes for the lower-envelope line store: request and
// response payloads, action and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int VAL_W   = 33;          // stored slope/intercept width
    localparam int ENTRY_W = 2 * VAL_W;   // {slope, intercept}
    localparam int OP_W    = 35;          // multiplier operand width
    localparam int PROD_W  = 2 * OP_W;    // full product width
    localparam int SUM_W   = 66;          // line value width

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_MONO = 2'd1;
    localparam logic [1:0] ACT_ARB  = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DOM   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // read port address selection
    localparam logic [2:0] RD_NONE = 3'd0;
    localparam logic [2:0] RD_TOP  = 3'd1;
    localparam logic [2:0] RD_POP  = 3'd2;
    localparam logic [2:0] RD_SCAN = 3'd3;
    localparam logic [2:0] RD_MID  = 3'd4;
    localparam logic [2:0] RD_FINS = 3'd5;
    localparam logic [2:0] RD_FINL = 3'd6;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] line_slope;
        logic signed [31:0] line_intercept;
        logic signed [31:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [63:0] envelope_value;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic       cap;
        logic [2:0] rd_sel;
        logic       push;
        logic       replace;
        logic       pop;
        logic       op_pop;
        logic       scan_clamp;
        logic       scan_inc;
        logic       bs_init;
        logic       bs_lo;
        logic       bs_hi;
        logic       set_val;
        logic       set_st;
        logic [1:0] st;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic is_mono;
        logic is_arb;
        logic lc_zero;
        logic lc_ge3;
        logic full;
        logic top_eq;
        logic top_dom;
        logic bad;
        logic scan_lt;
        logic lo_lt;
        logic le;
        logic out_busy;
    } sts_t;

endpackage

// ===== hw/rtl/chte_ram.sv =====
// ----------------------------------------------------------------------------
// chte_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/chte_ctrl.sv =====
// ----------------------------------------------------------------------------
// chte_ctrl
// Sequencer for insert, pop test, scan and binary-search queries.
// ----------------------------------------------------------------------------
module chte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  chte_pkg::sts_t  sts,
    output chte_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_TOPCHK = 4'd2;
    localparam logic [3:0] S_POPRD  = 4'd3;
    localparam logic [3:0] S_POPOP  = 4'd4;
    localparam logic [3:0] S_POPMUL = 4'd5;
    localparam logic [3:0] S_POPCHK = 4'd6;
    localparam logic [3:0] S_MCHK   = 4'd7;
    localparam logic [3:0] S_BCHK   = 4'd8;
    localparam logic [3:0] S_QOP    = 4'd9;
    localparam logic [3:0] S_QMUL   = 4'd10;
    localparam logic [3:0] S_QSUM   = 4'd11;
    localparam logic [3:0] S_QCHK   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       fin_reg;
    logic       fin_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.rd_sel = chte_pkg::RD_NONE;
        cmd.st     = chte_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap    = 1'b1;
                    fin_next   = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.is_add)
                begin
                    if (sts.lc_zero)
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_POPRD;
                    end
                    else
                    begin
                        cmd.rd_sel = chte_pkg::RD_TOP;
                        state_next = S_TOPCHK;
                    end
                end
                else if (sts.is_mono || sts.is_arb)
                begin
                    if (sts.lc_zero)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = chte_pkg::ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else if (sts.is_mono)
                    begin
                        cmd.scan_clamp = 1'b1;
                        state_next     = S_MCHK;
                    end
                    else
                    begin
                        cmd.bs_init = 1'b1;
                        state_next  = S_BCHK;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TOPCHK:
            begin
                if (sts.top_eq && sts.top_dom)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = chte_pkg::ST_DOM;
                    state_next = S_DONE;
                end
                else if (sts.top_eq)
                begin
                    cmd.replace = 1'b1;
                    state_next  = S_POPRD;
                end
                else if (sts.full)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = chte_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_POPRD;
                end
            end
            S_POPRD:
            begin
                if (sts.lc_ge3)
                begin
                    cmd.rd_sel = chte_pkg::RD_POP;
                    state_next = S_POPOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POPOP:
            begin
                cmd.op_pop = 1'b1;
                state_next = S_POPMUL;
            end
            S_POPMUL:
            begin
                state_next = S_POPCHK;
            end
            S_POPCHK:
            begin
                if (sts.bad)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MCHK:
            begin
                if (sts.scan_lt)
                begin
                    cmd.rd_sel = chte_pkg::RD_SCAN;
                end
                else
                begin
                    cmd.rd_sel = chte_pkg::RD_FINS;
                    fin_next   = 1'b1;
                end
                state_next = S_QOP;
            end
            S_BCHK:
            begin
                if (sts.lo_lt)
                begin
                    cmd.rd_sel = chte_pkg::RD_MID;
                end
                else
                begin
                    cmd.rd_sel = chte_pkg::RD_FINL;
                    fin_next   = 1'b1;
                end
                state_next = S_QOP;
            end
            S_QOP:
            begin
                state_next = S_QMUL;
            end
            S_QMUL:
            begin
                state_next = S_QSUM;
            end
            S_QSUM:
            begin
                state_next = S_QCHK;
            end
            S_QCHK:
            begin
                if (fin_reg)
                begin
                    cmd.set_val = 1'b1;
                    state_next  = S_DONE;
                end
                else if (sts.is_mono)
                begin
                    if (sts.le)
                    begin
                        cmd.scan_inc = 1'b1;
                        state_next   = S_MCHK;
                    end
                    else
                    begin
                        // current line wins: evaluate it as the answer
                        cmd.rd_sel = chte_pkg::RD_FINS;
                        fin_next   = 1'b1;
                        state_next = S_QOP;
                    end
                end
                else
                begin
                    cmd.bs_lo  = sts.le;
                    cmd.bs_hi  = !sts.le;
                    state_next = S_BCHK;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== hw/rtl/chte_dp.sv =====
// ----------------------------------------------------------------------------
// chte_dp
// Datapath: line store, counters, multiplier pipeline and response register.
// ----------------------------------------------------------------------------
module chte_dp #(
    parameter int MAX_LINES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            max_mode,
    input  chte_pkg::req_t  req,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output chte_pkg::rsp_t  rsp,
    input  chte_pkg::cmd_t  cmd,
    output chte_pkg::sts_t  sts
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int VW = chte_pkg::VAL_W;
    localparam int EW = chte_pkg::ENTRY_W;
    localparam int OW = chte_pkg::OP_W;
    localparam int PW = chte_pkg::PROD_W;
    localparam int SW = chte_pkg::SUM_W;

    chte_pkg::req_t         item_reg;
    logic signed [VW-1:0]   new_m_reg;
    logic signed [VW-1:0]   new_c_reg;
    logic signed [VW-1:0]   sx_m;
    logic signed [VW-1:0]   sx_c;

    logic [CW-1:0] lc_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] mid_reg;
    logic [CW-1:0] mid;
    logic [CW-1:0] lc_m1;
    logic [CW-1:0] lc_m2;
    logic [CW-1:0] lc_m3;
    logic [CW-1:0] scan_m1;
    logic [CW-1:0] mid_m1;
    logic [CW-1:0] lo_m1;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [EW-1:0] rdata_a;
    logic [EW-1:0] rdata_b;

    logic signed [VW-1:0] ma;
    logic signed [VW-1:0] ca;
    logic signed [VW-1:0] mb;
    logic signed [VW-1:0] cb;

    logic signed [VW:0]   da;
    logic signed [VW:0]   db;
    logic signed [VW:0]   dc;
    logic signed [VW:0]   dd;
    logic signed [VW:0]   na;
    logic signed [VW:0]   nb;
    logic signed [VW:0]   nc;
    logic signed [VW:0]   nd;

    logic signed [OW-1:0] opa0_reg;
    logic signed [OW-1:0] opb0_reg;
    logic signed [OW-1:0] opa1_reg;
    logic signed [OW-1:0] opb1_reg;
    logic signed [VW-1:0] ic0_op_reg;
    logic signed [VW-1:0] ic1_op_reg;
    logic                 zero_op_reg;

    logic signed [PW-1:0] prod0_reg;
    logic signed [PW-1:0] prod1_reg;
    logic signed [VW-1:0] ic0_pr_reg;
    logic signed [VW-1:0] ic1_pr_reg;
    logic                 zero_pr_reg;

    logic signed [SW-1:0] sum0_reg;
    logic signed [SW-1:0] sum1_reg;

    logic signed [63:0]   res_val_reg;
    logic [1:0]           res_st_reg;
    logic                 rsp_valid_reg;
    chte_pkg::rsp_t       rsp_reg;

    assign sx_m = {req.line_slope[31], req.line_slope};
    assign sx_c = {req.line_intercept[31], req.line_intercept};

    assign lc_m1   = lc_reg - CW'(1);
    assign lc_m2   = lc_reg - CW'(2);
    assign lc_m3   = lc_reg - CW'(3);
    assign scan_m1 = scan_reg - CW'(1);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_m1  = mid - CW'(1);
    assign lo_m1   = lo_reg - CW'(1);

    // read address decode
    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        unique case (cmd.rd_sel)
            chte_pkg::RD_TOP:
            begin
                raddr_a = lc_m1[AW-1:0];
            end
            chte_pkg::RD_POP:
            begin
                raddr_a = lc_m3[AW-1:0];
                raddr_b = lc_m2[AW-1:0];
            end
            chte_pkg::RD_SCAN:
            begin
                raddr_a = scan_m1[AW-1:0];
                raddr_b = scan_reg[AW-1:0];
            end
            chte_pkg::RD_MID:
            begin
                raddr_a = mid_m1[AW-1:0];
                raddr_b = mid[AW-1:0];
            end
            chte_pkg::RD_FINS:
            begin
                raddr_a = scan_m1[AW-1:0];
            end
            chte_pkg::RD_FINL:
            begin
                raddr_a = lo_m1[AW-1:0];
            end
            default:
            begin
                raddr_a = '0;
                raddr_b = '0;
            end
        endcase
    end

    // write: new entry on push, top on replace, next-to-top on pop
    assign we = cmd.push || cmd.replace || cmd.pop;
    always_comb
    begin
        if (cmd.push)
        begin
            waddr = lc_reg[AW-1:0];
        end
        else if (cmd.replace)
        begin
            waddr = lc_m1[AW-1:0];
        end
        else
        begin
            waddr = lc_m2[AW-1:0];
        end
    end

    chte_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LINES)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   ({new_m_reg, new_c_reg}),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign ma = rdata_a[EW-1:VW];
    assign ca = rdata_a[VW-1:0];
    assign mb = rdata_b[EW-1:VW];
    assign cb = rdata_b[VW-1:0];

    // pop test: j on port A, k on port B, l is the new line
    assign da = {new_c_reg[VW-1], new_c_reg} - {ca[VW-1], ca};
    assign db = {ma[VW-1], ma} - {new_m_reg[VW-1], new_m_reg};
    assign dc = {cb[VW-1], cb} - {ca[VW-1], ca};
    assign dd = {ma[VW-1], ma} - {mb[VW-1], mb};
    assign na = db[VW] ? -da : da;
    assign nb = db[VW] ? -db : db;
    assign nc = dd[VW] ? -dc : dc;
    assign nd = dd[VW] ? -dd : dd;

    always_ff @(posedge clk)
    begin
        if (cmd.op_pop)
        begin
            opa0_reg    <= {na[VW], na};
            opb0_reg    <= {nd[VW], nd};
            opa1_reg    <= {nc[VW], nc};
            opb1_reg    <= {nb[VW], nb};
            zero_op_reg <= (db == '0) || (dd == '0);
        end
        else
        begin
            opa0_reg    <= {{2{ma[VW-1]}}, ma};
            opb0_reg    <= {{3{item_reg.query_x[31]}}, item_reg.query_x};
            opa1_reg    <= {{2{mb[VW-1]}}, mb};
            opb1_reg    <= {{3{item_reg.query_x[31]}}, item_reg.query_x};
            zero_op_reg <= 1'b0;
        end
        ic0_op_reg  <= ca;
        ic1_op_reg  <= cb;
        prod0_reg   <= PW'(opa0_reg) * PW'(opb0_reg);
        prod1_reg   <= PW'(opa1_reg) * PW'(opb1_reg);
        ic0_pr_reg  <= ic0_op_reg;
        ic1_pr_reg  <= ic1_op_reg;
        zero_pr_reg <= zero_op_reg;
        sum0_reg    <= $signed(prod0_reg[SW-1:0]) + {{(SW-VW){ic0_pr_reg[VW-1]}}, ic0_pr_reg};
        sum1_reg    <= $signed(prod1_reg[SW-1:0]) + {{(SW-VW){ic1_pr_reg[VW-1]}}, ic1_pr_reg};
    end

    // item capture and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            item_reg    <= req;
            new_m_reg   <= max_mode ? -sx_m : sx_m;
            new_c_reg   <= max_mode ? -sx_c : sx_c;
            res_val_reg <= '0;
            res_st_reg  <= chte_pkg::ST_OK;
        end
        else
        begin
            if (cmd.set_st)
            begin
                res_st_reg <= cmd.st;
            end
            if (cmd.set_val)
            begin
                res_val_reg <= max_mode ? -sum0_reg[63:0] : sum0_reg[63:0];
            end
        end
        if (cmd.rd_sel == chte_pkg::RD_MID)
        begin
            mid_reg <= mid;
        end
        if (cmd.emit)
        begin
            rsp_reg.envelope_value <= res_val_reg;
            rsp_reg.status         <= res_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg        <= '0;
            scan_reg      <= CW'(1);
            lo_reg        <= CW'(1);
            hi_reg        <= CW'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                lc_reg <= lc_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                lc_reg <= lc_m1;
            end

            if (cmd.scan_clamp)
            begin
                if (scan_reg > lc_reg)
                begin
                    scan_reg <= lc_reg;
                end
                else if (scan_reg == '0)
                begin
                    scan_reg <= CW'(1);
                end
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + CW'(1);
            end

            if (cmd.bs_init)
            begin
                lo_reg <= CW'(1);
                hi_reg <= lc_reg;
            end
            else if (cmd.bs_lo)
            begin
                lo_reg <= mid_reg + CW'(1);
            end
            else if (cmd.bs_hi)
            begin
                hi_reg <= mid_reg;
            end

            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_add   = (item_reg.action == chte_pkg::ACT_ADD);
    assign sts.is_mono  = (item_reg.action == chte_pkg::ACT_MONO);
    assign sts.is_arb   = (item_reg.action == chte_pkg::ACT_ARB);
    assign sts.lc_zero  = (lc_reg == '0);
    assign sts.lc_ge3   = (lc_reg >= CW'(3));
    assign sts.full     = (lc_reg >= CW'(MAX_LINES));
    assign sts.top_eq   = (ma == new_m_reg);
    assign sts.top_dom  = (ca <= new_c_reg);
    assign sts.bad      = !zero_pr_reg && (prod0_reg <= prod1_reg);
    assign sts.scan_lt  = (scan_reg < lc_reg);
    assign sts.lo_lt    = (lo_reg < hi_reg);
    assign sts.le       = (sum1_reg <= sum0_reg);
    assign sts.out_busy = rsp_valid_reg && !rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/convex_hull_trick_envelope.sv =====
// ----------------------------------------------------------------------------
// convex_hull_trick_envelope
// Lower envelope of lines with monotonic slopes; min or max queries.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): add a line, a monotonic scan query
// or an arbitrary binary-search query. Each request yields exactly one
// response on rsp (valid/ready) with the envelope value and a status code.
// The APB port holds max_mode, which negates lines on insert and answers
// on output; write it only while the block is idle.
// One request is worked on at a time. An add reads the top line unless the
// stack is empty and, while three or more lines are stacked, runs pop tests,
// each a line-store read, the operand and product registers of the multiply
// and a compare. A monotonic query runs scan steps and an arbitrary query
// search probes (ceil(log2(lines)) probes), each a line-store read, the
// operand and product registers, the add and the compare; the chosen line
// is then evaluated through the same path.
// Reset empties the stack, sets the scan pointer to the first line and
// clears max_mode; the store needs no clearing pass.
// The response sits in an output register: a new request is taken while it
// waits, and a stalled receiver only holds the next result in its final
// step.
// ----------------------------------------------------------------------------
module convex_hull_trick_envelope #(
    parameter int MAX_LINES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  chte_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output chte_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    chte_pkg::cmd_t cmd;
    chte_pkg::sts_t sts;
    logic           max_mode_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, max_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            max_mode_reg <= pwdata[0];
        end
    end

    chte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chte_dp #(
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_mode  (max_mode_reg),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one request in flight: ready drops after every accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == chte_pkg::ST_EMPTY)) |-> (rsp.envelope_value == '0))
        else $error("empty response carries a value");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == chte_pkg::ST_DOM || rsp.status == chte_pkg::ST_FULL))
        |-> (rsp.envelope_value == '0))
        else $error("dropped line response carries a value");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (max_mode_reg == $past(pwdata[0])))
        else $error("max_mode write lost");

endmodule

// ===== test/tb_convex_hull_trick_envelope.sv =====
// ----------------------------------------------------------------------------
// tb_convex_hull_trick_envelope
// Self-checking bench for the lower-envelope line store. Requests (adds,
// monotonic and arbitrary queries) are driven with random gaps, responses
// are taken with random stalls. A predictor of the stack, the scan pointer
// and max_mode works out each response, and the checker compares it field
// by field in order.
// ----------------------------------------------------------------------------
module tb_convex_hull_trick_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH       = 1024;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [2:0] REG_MAX_MODE = 3'd0;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    chte_pkg::req_t  req;
    logic            rsp_valid;
    logic            rsp_ready;
    chte_pkg::rsp_t  rsp;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    // envelope predictor state
    longint      env_slope[DEPTH];
    longint      env_icpt[DEPTH];
    int          env_count;
    int          env_scan;
    bit          env_max;

    chte_pkg::rsp_t pending_rsp[$];
    int          errors;
    int          resp_seen;
    int          cycle_count;
    int          hold_cycles;
    int          stall_left;
    bit          quiet;
    longint      drift_slope;
    longint      drift_x;

    convex_hull_trick_envelope #(.MAX_LINES(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint line_at(int e, longint x);
        return env_slope[e] * x + env_icpt[e];
    endfunction

    // exact test: middle line k no longer on the envelope between j and l
    function automatic bit middle_hidden(int j, int k, int l);
        longint a, b, c, d;
        logic signed [127:0] wa, wb, wc, wd;
        a = env_icpt[l] - env_icpt[j];
        b = env_slope[j] - env_slope[l];
        c = env_icpt[k] - env_icpt[j];
        d = env_slope[j] - env_slope[k];
        if (b == 0 || d == 0)
            return 1'b0;
        if (b < 0)
        begin
            a = -a;
            b = -b;
        end
        if (d < 0)
        begin
            c = -c;
            d = -d;
        end
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return (wa * wd) <= (wc * wb);
    endfunction

    function automatic chte_pkg::rsp_t envelope_answer(chte_pkg::req_t r);
        chte_pkg::rsp_t o;
        longint m, cc, x, v;
        int     lo, hi, mid;
        bit     push;
        o = '0;
        v = 0;
        if (r.action == chte_pkg::ACT_ADD)
        begin
            m = r.line_slope;
            cc = r.line_intercept;
            push = 1'b1;
            if (env_max)
            begin
                m = -m;
                cc = -cc;
            end
            if (env_count > 0 && env_slope[env_count-1] == m)
            begin
                if (env_icpt[env_count-1] <= cc)
                begin
                    o.status = chte_pkg::ST_DOM;
                    push = 1'b0;
                end
                else
                    env_count--;
            end
            else if (env_count >= DEPTH)
            begin
                o.status = chte_pkg::ST_FULL;
                push = 1'b0;
            end
            if (push)
            begin
                env_slope[env_count] = m;
                env_icpt[env_count] = cc;
                env_count++;
                while (env_count >= 3
                       && middle_hidden(env_count-3, env_count-2, env_count-1))
                begin
                    env_slope[env_count-2] = env_slope[env_count-1];
                    env_icpt[env_count-2] = env_icpt[env_count-1];
                    env_count--;
                end
            end
        end
        else if (r.action == chte_pkg::ACT_MONO || r.action == chte_pkg::ACT_ARB)
        begin
            x = r.query_x;
            if (env_count == 0)
                o.status = chte_pkg::ST_EMPTY;
            else if (r.action == chte_pkg::ACT_MONO)
            begin
                if (env_scan > env_count)
                    env_scan = env_count;
                if (env_scan < 1)
                    env_scan = 1;
                while (env_scan < env_count
                       && line_at(env_scan, x) <= line_at(env_scan-1, x))
                    env_scan++;
                v = line_at(env_scan-1, x);
            end
            else
            begin
                lo = 1;
                hi = env_count;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (line_at(mid, x) <= line_at(mid-1, x))
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                v = line_at(lo-1, x);
            end
            if (env_max)
                v = -v;
        end
        o.envelope_value = v;
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on response %0d: %s got %0d expected %0d",
                 resp_seen, what, got, want);
        errors++;
    endtask

    // predict on request, check on response
    always @(posedge clk)
    begin
        chte_pkg::rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                pending_rsp.insert(pending_rsp.size(), envelope_answer(req));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                    report("unexpected response", 1, 0);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.envelope_value !== want.envelope_value)
                        report("value", rsp.envelope_value, want.envelope_value);
                    if (rsp.status !== want.status)
                        report("status", rsp.status, want.status);
                end
                resp_seen++;
            end
        end
    end

    // receiver: random stall per response, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles--;
        end
        else if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready && !quiet)
                stall_left = $urandom_range(0, 14);
        end
    end

    task automatic send(logic [1:0] act, logic [31:0] s, logic [31:0] c,
                        logic [31:0] x);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.action <= act;
        req.line_slope <= s;
        req.line_intercept <= c;
        req.query_x <= x;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // drop valid and wait until every response is in
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_max_mode(bit mode);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_MAX_MODE;
        pwdata <= {31'd0, mode};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        env_max = mode;
        if (prdata[0] !== mode)
            report("max_mode", prdata[0], mode);
        drift_slope = 64'sd1073741824;
        drift_x = -64'sd1073741824;
    endtask

    task automatic test_directed();
        write_max_mode(1'b0);
        send(chte_pkg::ACT_MONO, 0, 0, 32'h8000_0000);        // empty envelope
        send(chte_pkg::ACT_ARB, 0, 0, 32'h7fff_ffff);
        send(chte_pkg::ACT_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send(chte_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 0);
        send(chte_pkg::ACT_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0); // dominated
        send(chte_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0001, 0); // no: higher, dominated
        send(chte_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 0);
        send(chte_pkg::ACT_ADD, 0, 100, 0);
        send(chte_pkg::ACT_ADD, 32'h8000_0000, 32'h7fff_ffff, 0);
        send(chte_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 0); // replace top
        send(chte_pkg::ACT_ADD, 0, 5, 0);                     // slope order broken
        send(chte_pkg::ACT_ARB, 0, 0, 32'h8000_0000);
        send(chte_pkg::ACT_ARB, 0, 0, 32'h7fff_ffff);
        send(chte_pkg::ACT_MONO, 0, 0, 32'h8000_0000);
        send(chte_pkg::ACT_MONO, 0, 0, 32'h7fff_ffff);
        send(chte_pkg::ACT_ADD, -20, 400, 0);                 // pops, scan goes stale
        send(chte_pkg::ACT_ADD, -30, 900, 0);
        send(chte_pkg::ACT_MONO, 0, 0, 0);
        write_max_mode(1'b1);
        send(chte_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 0);
        send(chte_pkg::ACT_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send(chte_pkg::ACT_ARB, 0, 0, 32'h8000_0000);
        send(chte_pkg::ACT_MONO, 0, 0, 32'h7fff_ffff);
    endtask

    task automatic random_phase(int n);
        int     pick;
        longint s;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                drift_slope -= $urandom_range(0, 1 << 20);
                s = env_max ? -drift_slope : drift_slope;
                send(chte_pkg::ACT_ADD, s[31:0], $urandom(), $urandom());
            end
            else if (pick < 68)
            begin
                drift_x += $urandom_range(0, 1 << 21);
                send(chte_pkg::ACT_MONO, $urandom(), $urandom(), drift_x[31:0]);
            end
            else if (pick < 86)
                send(chte_pkg::ACT_ARB, $urandom(), $urandom(), $urandom());
            else if (pick < 95)
                send(chte_pkg::ACT_ADD, $urandom(), $urandom(), $urandom());
            else
                send(chte_pkg::ACT_NONE, $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic test_random();
        write_max_mode(1'b0);
        random_phase(90);
        quiet = 1'b1;
        random_phase(40);
        quiet = 1'b0;
        write_max_mode(1'b1);
        random_phase(90);
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send(chte_pkg::ACT_ARB, 0, 0, $urandom());
        quiet = 1'b0;
        drain();
        for (int i = 0; i < 20; i++)
            send(chte_pkg::ACT_MONO, 0, 0, $urandom());
    endtask

    task automatic test_full_store();
        longint s;
        write_max_mode(1'b0);
        // strictly convex run: none of these lines hides another
        for (int k = 0; k < 1100; k++)
        begin
            s = -64'sd1073741824 - k;
            send(chte_pkg::ACT_ADD, s[31:0], k * k, 0);
        end
        s = -64'sd1073741824 - 1099;
        send(chte_pkg::ACT_ADD, s[31:0], 1099 * 1099 - 7, 0); // slope of a refused line, not the top: refused as full
        send(chte_pkg::ACT_ADD, s[31:0], 32'h7fff_ffff, 0);
        for (int i = 0; i < 8; i++)
        begin
            send(chte_pkg::ACT_ARB, 0, 0, $urandom_range(0, 2500));
            send(chte_pkg::ACT_MONO, 0, 0, i * 300);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        resp_seen = 0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_left = 0;
        quiet = 1'b0;
        env_count = 0;
        env_scan = 1;
        env_max = 1'b0;
        foreach (env_slope[i])
        begin
            env_slope[i] = 0;
            env_icpt[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_full_store();
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/chte_pkg.sv
hw/rtl/chte_ram.sv
hw/rtl/chte_ctrl.sv
hw/rtl/chte_dp.sv
hw/rtl/convex_hull_trick_envelope.sv
test/tb_convex_hull_trick_envelope.sv
